// ----- rtl/core/nca_pkg.sv -----
// shared types and constants of the nearest-centroid assignment block
package nca_pkg;

	localparam int DIST_WIDTH  = 49;
	localparam int INDEX_WIDTH = 5;
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_APPEND   = 2'd1,
		REQ_CLASSIFY = 2'd2,
		REQ_NONE     = 2'd3
	} nca_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} nca_state_t;

	// scan position markers that travel with each centroid through the pipeline
	typedef struct packed {
		logic first;
		logic last;
	} nca_flags_t;

endpackage

// ----- rtl/core/nearest_centroid_assign.sv -----
// top level of the nearest-centroid assignment block with its scan sequencer
//
// k-means assignment step in 2-D. Each transfer on the command side (start
// high while busy is low) carries a request: clear empties the centroid
// table, append stores one centroid (flagged append_dropped once the table
// holds MAX_CENTROIDS), classify finds the loaded centroid with the least
// squared distance to the point, lowest index first on ties. Clear and the
// unused request code give no result. Append and classify give exactly one
// result, shown for a single cycle with done high; the receiver cannot hold
// it off, so it must take every strobe. Clear and append leave busy low and
// the next command may follow in the next cycle; the append result comes in
// the cycle after its transfer. A classify on an empty table answers in the
// cycle after its transfer with no_centroid and zero fields. A classify on a
// non-empty table keeps busy high until its scan is done and shows its result in the
// first cycle with busy low: the centroid memory has one read port and
// one distance pipeline (difference, square, sum) serves every entry, one
// entry per cycle, followed by one compare stage. Coordinates are signed
// two's complement with 8 fraction bits; min_distance carries 16 fraction
// bits and saturates at its all-ones value.
module nearest_centroid_assign
	import nca_pkg::*;
#(
	parameter int MAX_CENTROIDS = 32,
	parameter int COORD_WIDTH   = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                         done,
	output logic [INDEX_WIDTH-1:0]       nearest_index,
	output logic signed [COORD_WIDTH-1:0] nearest_x,
	output logic signed [COORD_WIDTH-1:0] nearest_y,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic [DIST_WIDTH-1:0]        min_distance,
	output logic                         no_centroid,
	output logic                         append_dropped
);

	localparam int CW   = COORD_WIDTH;
	localparam int AW   = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
	localparam int CNTW = $clog2(MAX_CENTROIDS + 1);

	// sequencer
	nca_state_t state_q, state_d;
	logic       accept;
	logic       issue;
	logic       issue_last;
	logic       tbl_full;
	logic       tbl_empty;

	// table bookkeeping and the held point
	logic [CNTW-1:0]        count_q;
	logic [AW-1:0]          scan_q;
	logic signed [CW-1:0]   px_q, py_q;

	// read stage, aligned with the memory's registered data
	logic                   rd_vld_s1;
	nca_flags_t             rd_flags_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic [2*CW-1:0]        rd_data;

	// distance pipeline outputs
	logic                   d_vld;
	nca_flags_t             d_flags;
	logic [AW-1:0]          d_idx;
	logic signed [CW-1:0]   d_cx, d_cy;
	logic [DIST_WIDTH-1:0]  d_dist;

	// running minimum
	logic                   take;
	logic [DIST_WIDTH-1:0]  best_d_q;
	logic [AW-1:0]          best_idx_q;
	logic signed [CW-1:0]   best_x_q, best_y_q;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign tbl_full   = (count_q == CNTW'(MAX_CENTROIDS));
	assign tbl_empty  = (count_q == '0);
	assign issue      = (state_q == ST_SCAN);
	assign issue_last = (CNTW'(scan_q) + CNTW'(1)) == count_q;

	// strict compare keeps the earliest entry on ties
	assign take = d_flags.first || (d_dist < best_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (nca_req_t'(req_type) == REQ_CLASSIFY) && !tbl_empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (d_vld && d_flags.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table count, scan address and read-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept) begin
				case (nca_req_t'(req_type))
					REQ_CLEAR: begin
						count_q <= '0;
					end
					REQ_APPEND: begin
						if (!tbl_full) begin
							count_q <= count_q + CNTW'(1);
						end
					end
					default: begin
					end
				endcase
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		rd_flags_s1.first <= (scan_q == '0);
		rd_flags_s1.last  <= issue_last;
		rd_idx_s1         <= scan_q;
	end

	nca_cstore #(
		.DEPTH (MAX_CENTROIDS),
		.WIDTH (2 * CW)
	) u_cstore (
		.clk     (clk),
		.wr_en   (accept && (nca_req_t'(req_type) == REQ_APPEND) && !tbl_full),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({coord_x, coord_y}),
		.rd_en   (issue),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	nca_dist #(
		.CW (CW),
		.IW (AW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rd_vld_s1),
		.in_flags  (rd_flags_s1),
		.in_idx    (rd_idx_s1),
		.px        (px_q),
		.py        (py_q),
		.cx        (rd_data[2*CW-1:CW]),
		.cy        (rd_data[CW-1:0]),
		.out_vld   (d_vld),
		.out_flags (d_flags),
		.out_idx   (d_idx),
		.out_cx    (d_cx),
		.out_cy    (d_cy),
		.out_dist  (d_dist)
	);

	// running minimum over the scan
	always_ff @(posedge clk) begin
		if (d_vld && take) begin
			best_d_q   <= d_dist;
			best_idx_q <= d_idx;
			best_x_q   <= d_cx;
			best_y_q   <= d_cy;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (accept && ((nca_req_t'(req_type) == REQ_APPEND)
				|| ((nca_req_t'(req_type) == REQ_CLASSIFY) && tbl_empty)))
				|| (d_vld && d_flags.last);
		end
	end

	// result payload; append and empty-table answers carry zero fields
	always_ff @(posedge clk) begin
		if (d_vld && d_flags.last) begin
			nearest_index  <= take ? INDEX_WIDTH'(d_idx) : INDEX_WIDTH'(best_idx_q);
			nearest_x      <= take ? d_cx : best_x_q;
			nearest_y      <= take ? d_cy : best_y_q;
			min_distance   <= take ? d_dist : best_d_q;
			point_x        <= px_q;
			point_y        <= py_q;
			no_centroid    <= 1'b0;
			append_dropped <= 1'b0;
		end else if (accept) begin
			nearest_index  <= '0;
			nearest_x      <= '0;
			nearest_y      <= '0;
			min_distance   <= '0;
			point_x        <= '0;
			point_y        <= '0;
			no_centroid    <= (nca_req_t'(req_type) == REQ_CLASSIFY) && tbl_empty;
			append_dropped <= (nca_req_t'(req_type) == REQ_APPEND) && tbl_full;
		end
	end

	// every result strobe, a finished scan included, finds the block ready
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the table never holds more entries than it has room for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_CENTROIDS))
		else $error("centroid count beyond table depth");

	// distance results only arrive during a classify
	a_dist_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		d_vld |-> busy)
		else $error("distance result outside a scan");

	// the two flags describe different requests
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(no_centroid && append_dropped))
		else $error("both result flags set");

endmodule

// ----- rtl/core/nca_cstore.sv -----
// centroid memory, one write port and one registered read port
module nca_cstore
	import nca_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int WIDTH = 48,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/nca_dist.sv -----
// shared squared-distance pipeline: difference, square, sum with saturation
module nca_dist
	import nca_pkg::*;
#(
	parameter int CW = 24,
	parameter int IW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  nca_flags_t            in_flags,
	input  logic [IW-1:0]         in_idx,
	input  logic signed [CW-1:0]  px,
	input  logic signed [CW-1:0]  py,
	input  logic signed [CW-1:0]  cx,
	input  logic signed [CW-1:0]  cy,
	output logic                  out_vld,
	output nca_flags_t            out_flags,
	output logic [IW-1:0]         out_idx,
	output logic signed [CW-1:0]  out_cx,
	output logic signed [CW-1:0]  out_cy,
	output logic [DIST_WIDTH-1:0] out_dist
);

	localparam int PW = 2 * (CW + 1);
	localparam int SW = PW + 1;
	localparam int EW = (SW > DIST_WIDTH) ? SW : DIST_WIDTH;

	logic signed [CW:0] dx, dy;
	logic [CW:0]        adx, ady;
	logic [EW-1:0]      sum_ext;

	logic [CW:0]        ax_s1, ay_s1;
	logic [PW-1:0]      sqx_s2, sqy_s2;
	logic [2:0]         vld_q;
	nca_flags_t         flags_s1, flags_s2, flags_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic signed [CW-1:0] cx_s1, cx_s2, cx_s3, cy_s1, cy_s2, cy_s3;
	logic [DIST_WIDTH-1:0] dist_s3;

	assign dx  = {px[CW-1], px} - {cx[CW-1], cx};
	assign dy  = {py[CW-1], py} - {cy[CW-1], cy};
	assign adx = dx[CW] ? (~dx + 1'b1) : dx;
	assign ady = dy[CW] ? (~dy + 1'b1) : dy;
	assign sum_ext = EW'(SW'(sqx_s2) + SW'(sqy_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: absolute differences
		ax_s1    <= adx;
		ay_s1    <= ady;
		flags_s1 <= in_flags;
		idx_s1   <= in_idx;
		cx_s1    <= cx;
		cy_s1    <= cy;
		// stage 2: squares
		sqx_s2   <= ax_s1 * ax_s1;
		sqy_s2   <= ay_s1 * ay_s1;
		flags_s2 <= flags_s1;
		idx_s2   <= idx_s1;
		cx_s2    <= cx_s1;
		cy_s2    <= cy_s1;
		// stage 3: sum, clamped to the result width
		dist_s3  <= (sum_ext > EW'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(sum_ext);
		flags_s3 <= flags_s2;
		idx_s3   <= idx_s2;
		cx_s3    <= cx_s2;
		cy_s3    <= cy_s2;
	end

	assign out_vld   = vld_q[2];
	assign out_flags = flags_s3;
	assign out_idx   = idx_s3;
	assign out_cx    = cx_s3;
	assign out_cy    = cy_s3;
	assign out_dist  = dist_s3;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the nearest-centroid assignment block
module tb_top
	import nca_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 32;
	localparam int CW          = 24;
	localparam int RANDOM_ITEMS = 450;
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

	// one command for the block; hold makes the sender wait for every open answer first
	typedef struct {
		nca_req_t               req;
		logic signed [CW-1:0]   x;
		logic signed [CW-1:0]   y;
		bit                     hold;
	} cmd_t;

	// one answer as it should appear on the result ports
	typedef struct {
		logic [INDEX_WIDTH-1:0] idx;
		logic signed [CW-1:0]   cx;
		logic signed [CW-1:0]   cy;
		logic signed [CW-1:0]   px;
		logic signed [CW-1:0]   py;
		logic [DIST_WIDTH-1:0]  dist_sq;
		logic                   empty;
		logic                   dropped;
	} answer_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   req_type;
	logic signed [CW-1:0]         coord_x;
	logic signed [CW-1:0]         coord_y;
	logic                         done;
	logic [INDEX_WIDTH-1:0]       nearest_index;
	logic signed [CW-1:0]         nearest_x;
	logic signed [CW-1:0]         nearest_y;
	logic signed [CW-1:0]         point_x;
	logic signed [CW-1:0]         point_y;
	logic [DIST_WIDTH-1:0]        min_distance;
	logic                         no_centroid;
	logic                         append_dropped;

	// commands waiting to go out, answers waiting to come back
	cmd_t    cmd_backlog[$];
	answer_t answers_due[$];

	// our own copy of the centroid table
	logic signed [CW-1:0] shadow_x[TABLE_DEPTH];
	logic signed [CW-1:0] shadow_y[TABLE_DEPTH];
	int                   shadow_count;

	int mismatches;

	nearest_centroid_assign DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.done           (done),
		.nearest_index  (nearest_index),
		.nearest_x      (nearest_x),
		.nearest_y      (nearest_y),
		.point_x        (point_x),
		.point_y        (point_y),
		.min_distance   (min_distance),
		.no_centroid    (no_centroid),
		.append_dropped (append_dropped)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// table model: apply one accepted command and queue its answer
	// ---------------------------------------------------------------
	function automatic void table_step(input nca_req_t req, input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		answer_t   a;
		longint    dx;
		longint    dy;
		longint    d;
		longint    best_d;
		int        best;
		a = '{default: '0};
		best_d = 0;
		best = 0;
		case (req)
			REQ_CLEAR: begin
				shadow_count = 0;
				return;
			end
			REQ_NONE: return;
			REQ_APPEND: begin
				// a full table keeps its contents and flags the drop
				if (shadow_count >= TABLE_DEPTH) begin
					a.dropped = 1'b1;
				end else begin
					shadow_x[shadow_count] = x;
					shadow_y[shadow_count] = y;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					// nothing loaded: flag only, point is not echoed
					a.empty = 1'b1;
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						dx = longint'(x) - longint'(shadow_x[i]);
						dy = longint'(y) - longint'(shadow_y[i]);
						d = dx * dx + dy * dy;
						if (d > longint'(DIST_MAX))
							d = longint'(DIST_MAX);
						// strict less-than keeps the lowest index on ties
						if (i == 0 || d < best_d) begin
							best_d = d;
							best = i;
						end
					end
					a.idx     = best[INDEX_WIDTH-1:0];
					a.cx      = shadow_x[best];
					a.cy      = shadow_y[best];
					a.px      = x;
					a.py      = y;
					a.dist_sq = best_d[DIST_WIDTH-1:0];
				end
			end
		endcase
		answers_due = {answers_due, a};
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------
	// driver: bursts of commands with random gaps, holds start until busy is low
	// ---------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		logic  go;
		cmd_t  c;
		if (!arst_n) begin
			start      <= 1'b0;
			req_type   <= REQ_NONE;
			coord_x    <= '0;
			coord_y    <= '0;
			burst_left <= 4;
			gap_left   <= 0;
		end else begin
			go = start;
			// transfer of the command now on the bus
			if (start && !busy) begin
				table_step(nca_req_t'(req_type), coord_x, coord_y);
				go = 1'b0;
			end
			// choose the next command only when the bus is free
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].hold && answers_due.size() != 0)) begin
					c = cmd_backlog.pop_front();
					req_type <= c.req;
					coord_x  <= c.x;
					coord_y  <= c.y;
					go = 1'b1;
					if (burst_left <= 1) begin
						// some bursts run long with no idle at all
						burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			start <= go;
		end
	end

	// ---------------------------------------------------------------
	// monitor: every done strobe is one answer, compared with the oldest due
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$error("result with no command waiting for it");
				mismatches++;
			end else begin
				a = answers_due.pop_front();
				check_field("nearest_index", a.idx, nearest_index);
				check_field("nearest_x", a.cx, nearest_x);
				check_field("nearest_y", a.cy, nearest_y);
				check_field("point_x", a.px, point_x);
				check_field("point_y", a.py, point_y);
				check_field("min_distance", a.dist_sq, min_distance);
				check_field("no_centroid", a.empty, no_centroid);
				check_field("append_dropped", a.dropped, append_dropped);
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic void queue_cmd(input nca_req_t req, input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input bit hold = 1'b0);
		cmd_t c;
		c.req  = req;
		c.x    = x;
		c.y    = y;
		c.hold = hold;
		cmd_backlog = {cmd_backlog, c};
	endfunction

	// mix of full-range, small, tiny (ties likely) and extreme coordinates
	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return C_MIN;
			1:       return C_MAX;
			2, 3, 4: return CW'($signed($urandom_range(0, 8)) - 4);
			5:       return CW'($signed($urandom_range(0, 2048)) - 1024);
			default: return CW'($urandom);
		endcase
	endfunction

	initial begin
		int counted;
		int n;
		int settle;
		bit hold;
		mismatches   = 0;
		shadow_count = 0;
		counted      = 0;
		arst_n       = 1'b0;

		// directed opening
		queue_cmd(REQ_CLASSIFY, 24'sd0, 24'sd0);        // empty table right after reset
		queue_cmd(REQ_NONE, C_MAX, C_MIN);               // unused code, ignored
		queue_cmd(REQ_APPEND, C_MAX, C_MAX);
		queue_cmd(REQ_APPEND, C_MIN, C_MIN);
		queue_cmd(REQ_CLASSIFY, C_MIN, C_MIN);          // exact hit on the second entry
		queue_cmd(REQ_CLASSIFY, C_MAX, C_MIN);          // largest distance, tie -> first
		queue_cmd(REQ_CLASSIFY, C_MIN, C_MAX);
		queue_cmd(REQ_APPEND, 24'sd0, 24'sd0);
		queue_cmd(REQ_APPEND, 24'sd0, 24'sd0);           // duplicate centroid
		queue_cmd(REQ_CLASSIFY, 24'sd1, -24'sd1);       // duplicates tie, lower index wins
		queue_cmd(REQ_CLASSIFY, 24'sd0, 24'sd0);
		queue_cmd(REQ_CLEAR, 24'sd0, 24'sd0, 1'b1);      // drain everything before this one
		queue_cmd(REQ_CLASSIFY, 24'sd5, 24'sd5);        // empty again after clear
		queue_cmd(REQ_APPEND, -24'sd1, 24'sd1);
		queue_cmd(REQ_CLASSIFY, C_MAX, C_MAX);
		queue_cmd(REQ_NONE, 24'sd0, 24'sd0);
		queue_cmd(REQ_CLEAR, C_MIN, C_MAX);

		// random part: mostly well-formed clear / load / classify sequences
		while (counted < RANDOM_ITEMS) begin
			hold = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any code in any order, clear included, with no clear queued ahead of it
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					queue_cmd(nca_req_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
						hold && i == 0);
					if (cmd_backlog[$].req != REQ_NONE)
						counted++;
				end
			end else begin
				if ($urandom_range(0, 9) != 0) begin
					queue_cmd(REQ_CLEAR, rand_coord(), rand_coord(), hold);
					hold = 1'b0;
					counted++;
				end
				// table sizes: mostly small, now and then near full, full or past full
				case ($urandom_range(0, 9))
					0:       n = $urandom_range(30, 36);
					1, 2:    n = $urandom_range(7, 20);
					default: n = $urandom_range(1, 6);
				endcase
				for (int i = 0; i < n; i++) begin
					queue_cmd(REQ_APPEND, rand_coord(), rand_coord(), hold);
					hold = 1'b0;
					counted++;
				end
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					queue_cmd(REQ_CLASSIFY, rand_coord(), rand_coord());
					counted++;
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// everything sent and taken
		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		// let the last answers arrive
		settle = 0;
		while (answers_due.size() != 0 && settle < 200) begin
			@(posedge clk);
			settle++;
		end
		repeat (40) @(posedge clk);
		if (answers_due.size() != 0) begin
			$error("%0d results never arrived", answers_due.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/nca_pkg.sv
rtl/core/nca_cstore.sv
rtl/core/nca_dist.sv
rtl/core/nearest_centroid_assign.sv
tb/tb_top.sv
